// ===== design/rlpe_pkg.sv =====
package rlpe_pkg;

    localparam int MAX_PAD_SLOTS   = 40;
    localparam int SLOTS_PER_PIXEL = 24;
    localparam int DUTY_W          = 16;
    localparam int CHAN_W          = 8;
    localparam int PAD_W           = 6;
    localparam int BCNT_W          = $clog2(SLOTS_PER_PIXEL + 1);
    localparam int CFG_IDX_W       = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_ONE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_ZERO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_ON    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SLOTS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_SLOTS  = 3'd4;

    // Input operation codes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_EOF   = 1'b1;

    // Control that every cell of the bit chain sees.
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    // Pad counts above the limit saturate.
    function automatic logic [PAD_W-1:0] clamp_pad(input logic [PAD_W-1:0] n);
        logic [PAD_W-1:0] lim;
        lim = PAD_W'(MAX_PAD_SLOTS);
        return (n > lim) ? lim : n;
    endfunction

endpackage

// ===== design/rlpe_cell.sv =====
module rlpe_cell
    import rlpe_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_load_bit,
    input  logic      i_prev_bit,
    output logic      o_bit
);

    logic r_bit;
    logic n_bit;

    always_comb begin
        n_bit = r_bit;
        if (i_ctl.load) begin
            n_bit = i_load_bit;
        end else if (i_ctl.shift) begin
            n_bit = i_prev_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
    end

    assign o_bit = r_bit;

endmodule

// ===== design/rlpe_shaper.sv =====
module rlpe_shaper
    import rlpe_pkg::*;
(
    input  logic              i_gamma_on,
    input  logic [CHAN_W-1:0] i_value,
    output logic [CHAN_W-1:0] o_value
);

    logic [2*CHAN_W-1:0] sq_plus;

    // Square gamma: (v*v + v) >> 8; the sum never exceeds 16 bits.
    assign sq_plus = (2*CHAN_W)'(i_value) * (2*CHAN_W)'(i_value) + (2*CHAN_W)'(i_value);
    assign o_value = i_gamma_on ? sq_plus[2*CHAN_W-1:CHAN_W] : i_value;

endmodule

// ===== design/rgb_led_pulse_encoder.sv =====
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+---------------------------------
// input     | in        | i_in_valid / o_in_stall   | i_in_op, i_in_red/green/blue
// output    | out       | o_out_valid / i_out_stall | o_out_duty, o_out_last_of_run
// config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A pixel beat produces 24 output beats, plus up to 40 leading zero slots when it
// opens a frame; an end-of-frame beat produces 0 to 40 zero slots. One slot leaves
// per cycle while the output is not stalled; a pixel's 24 slots come from the 24-cell bit chain.
// The next input beat is taken in the cycle the final slot of the current one moves
// into the output register, so runs follow each other without a gap.
// Reset (i_rst_n low at a clock edge) empties the run counters, clears the output valid and
// the frame flag, and clears all configuration registers; the bit chain and output payload are not reset.
// A stall on the output freezes the chain and the counters; the input stalls too while busy.
module rgb_led_pulse_encoder
    import rlpe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DUTY_W-1:0]    i_cfg_data,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_in_op,
    input  logic [CHAN_W-1:0]    i_in_red,
    input  logic [CHAN_W-1:0]    i_in_green,
    input  logic [CHAN_W-1:0]    i_in_blue,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [DUTY_W-1:0]    o_out_duty,
    output logic                 o_out_last_of_run
);

    // Configuration registers.
    logic [DUTY_W-1:0] r_duty_one;
    logic [DUTY_W-1:0] r_duty_zero;
    logic              r_gamma_on;
    logic [PAD_W-1:0]  r_start_slots;
    logic [PAD_W-1:0]  r_tail_slots;

    // Run state: zero slots still to send, then pixel bits still to send.
    logic [PAD_W-1:0]  r_pad_cnt,  n_pad_cnt;
    logic [BCNT_W-1:0] r_bits_cnt, n_bits_cnt;
    logic              r_in_frame, n_in_frame;

    // Output register.
    logic              r_out_valid;
    logic [DUTY_W-1:0] r_out_duty;
    logic              r_out_last;

    logic                       busy;
    logic                       out_free;
    logic                       advance;
    logic                       slot_is_pad;
    logic                       slot_last;
    logic                       in_accept;
    logic [CHAN_W-1:0]          red_s, green_s, blue_s;
    logic [SLOTS_PER_PIXEL-1:0] load_bits;
    logic [SLOTS_PER_PIXEL-1:0] cell_bits;
    t_cell_ctl                  cell_ctl;

    // Configuration is always accepted; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_one    <= '0;
            r_duty_zero   <= '0;
            r_gamma_on    <= 1'b0;
            r_start_slots <= '0;
            r_tail_slots  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DUTY_ONE:    r_duty_one    <= i_cfg_data;
                CFG_DUTY_ZERO:   r_duty_zero   <= i_cfg_data;
                CFG_GAMMA_ON:    r_gamma_on    <= i_cfg_data[0];
                CFG_START_SLOTS: r_start_slots <= i_cfg_data[PAD_W-1:0];
                CFG_TAIL_SLOTS:  r_tail_slots  <= i_cfg_data[PAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Gamma shaping of each channel on the way into the chain.
    rlpe_shaper u_shape_r (.i_gamma_on(r_gamma_on), .i_value(i_in_red),   .o_value(red_s));
    rlpe_shaper u_shape_g (.i_gamma_on(r_gamma_on), .i_value(i_in_green), .o_value(green_s));
    rlpe_shaper u_shape_b (.i_gamma_on(r_gamma_on), .i_value(i_in_blue),  .o_value(blue_s));

    // The top cell holds the first bit to send: green MSB first, then red, then blue.
    assign load_bits = {green_s, red_s, blue_s};

    // Slot sequencing. Zero slots go out before the pixel bits of the same run.
    assign busy        = (r_pad_cnt != '0) || (r_bits_cnt != '0);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = busy && out_free;
    assign slot_is_pad = (r_pad_cnt != '0);
    assign slot_last   = slot_is_pad ? ((r_pad_cnt == PAD_W'(1)) && (r_bits_cnt == '0))
                                     : (r_bits_cnt == BCNT_W'(1));

    // A new beat is taken when the engine is empty or is sending its final slot.
    assign o_in_stall = busy && !(advance && slot_last);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign cell_ctl.load  = in_accept && (i_in_op == OP_PIXEL);
    assign cell_ctl.shift = advance && !slot_is_pad;

    // Bit chain: each cell takes its lower neighbor's bit on a shift.
    genvar g;
    generate
        for (g = 0; g < SLOTS_PER_PIXEL; g++) begin : g_cell
            if (g == 0) begin : g_bottom
                rlpe_cell u_cell (
                    .i_clk      (i_clk),
                    .i_ctl      (cell_ctl),
                    .i_load_bit (load_bits[g]),
                    .i_prev_bit (1'b0),
                    .o_bit      (cell_bits[g])
                );
            end else begin : g_upper
                rlpe_cell u_cell (
                    .i_clk      (i_clk),
                    .i_ctl      (cell_ctl),
                    .i_load_bit (load_bits[g]),
                    .i_prev_bit (cell_bits[g-1]),
                    .o_bit      (cell_bits[g])
                );
            end
        end
    endgenerate

    always_comb begin
        n_pad_cnt  = r_pad_cnt;
        n_bits_cnt = r_bits_cnt;
        n_in_frame = r_in_frame;
        if (advance) begin
            if (slot_is_pad) begin
                n_pad_cnt = r_pad_cnt - PAD_W'(1);
            end else begin
                n_bits_cnt = r_bits_cnt - BCNT_W'(1);
            end
        end
        if (in_accept) begin
            if (i_in_op == OP_EOF) begin
                // An end of frame outside a frame still sends its tail.
                n_pad_cnt  = clamp_pad(r_tail_slots);
                n_bits_cnt = '0;
                n_in_frame = 1'b0;
            end else begin
                n_pad_cnt  = r_in_frame ? '0 : clamp_pad(r_start_slots);
                n_bits_cnt = BCNT_W'(SLOTS_PER_PIXEL);
                n_in_frame = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_cnt   <= '0;
            r_bits_cnt  <= '0;
            r_in_frame  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pad_cnt  <= n_pad_cnt;
            r_bits_cnt <= n_bits_cnt;
            r_in_frame <= n_in_frame;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload needs no reset; it only matters while valid is high.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (slot_is_pad) begin
                r_out_duty <= '0;
            end else begin
                r_out_duty <= cell_bits[SLOTS_PER_PIXEL-1] ? r_duty_one : r_duty_zero;
            end
            r_out_last <= slot_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_duty        = r_out_duty;
    assign o_out_last_of_run = r_out_last;

endmodule

// ===== bench/rgb_led_pulse_encoder_tb.sv =====
`timescale 1ns / 1ps

module rgb_led_pulse_encoder_tb;
    import rlpe_pkg::*;

    // Pacing of both sides. A side waits up to STALL_MAX per beat.
    // The receiver holds off once for HOLD_CYCLES so that the encoder backs up.
    localparam int STALL_MAX       = 14;
    localparam int HOLD_CYCLES     = 300;
    // A short pause after the last expected slot has left, before a register write.
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 30;
    // The run stops if this many cycles pass without any beat on any channel.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RAND_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 16;

    // One duty slot as it leaves the encoder.
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              last_of_run;
    } t_led_slot;

    // Predicts the duty slot stream of the encoder and holds the slots not yet seen.
    // It keeps its own copy of the registers and of the frame flag.
    class duty_slot_predictor;
        logic [DUTY_W-1:0] duty_one;
        logic [DUTY_W-1:0] duty_zero;
        logic              gamma_on;
        logic [PAD_W-1:0]  start_slots;
        logic [PAD_W-1:0]  tail_slots;
        logic              in_frame;
        t_led_slot         expected_slots[$];
        int                errors;

        function new();
            duty_one    = '0;
            duty_zero   = '0;
            gamma_on    = 1'b0;
            start_slots = '0;
            tail_slots  = '0;
            in_frame    = 1'b0;
            errors      = 0;
        endfunction

        // Writes to an index outside the register map are dropped.
        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUTY_W-1:0] data);
            case (idx)
                CFG_DUTY_ONE:    duty_one    = data;
                CFG_DUTY_ZERO:   duty_zero   = data;
                CFG_GAMMA_ON:    gamma_on    = data[0];
                CFG_START_SLOTS: start_slots = data[PAD_W-1:0];
                CFG_TAIL_SLOTS:  tail_slots  = data[PAD_W-1:0];
                default: ;
            endcase
        endfunction

        // The square gamma curve is (v*v+v)>>8, which still fits in 16 bits.
        function logic [CHAN_W-1:0] shaped(input logic [CHAN_W-1:0] v);
            logic [2*CHAN_W-1:0] sq;
            sq = v * v + v;
            return gamma_on ? sq[2*CHAN_W-1:CHAN_W] : v;
        endfunction

        function void push_slots(input int count, input logic [DUTY_W-1:0] duty);
            t_led_slot slot;
            slot.duty        = duty;
            slot.last_of_run = 1'b0;
            repeat (count) expected_slots.push_back(slot);
        endfunction

        function void take_beat(input logic op, input logic [CHAN_W-1:0] red,
                                input logic [CHAN_W-1:0] green, input logic [CHAN_W-1:0] blue);
            int                  queued;
            int                  k;
            logic [3*CHAN_W-1:0] grb;
            t_led_slot           slot;
            queued = expected_slots.size();
            if (op == OP_EOF) begin
                // Latch slots go out even when no frame is open.
                push_slots((tail_slots > MAX_PAD_SLOTS) ? MAX_PAD_SLOTS : int'(tail_slots), '0);
                in_frame = 1'b0;
            end else begin
                grb = {shaped(green), shaped(red), shaped(blue)};
                if (!in_frame) begin
                    push_slots((start_slots > MAX_PAD_SLOTS) ? MAX_PAD_SLOTS : int'(start_slots),
                               '0);
                    in_frame = 1'b1;
                end
                for (k = 3*CHAN_W-1; k >= 0; k--)
                    push_slots(1, grb[k] ? duty_one : duty_zero);
            end
            // Flag the final slot of this beat, if it caused any.
            if (expected_slots.size() > queued) begin
                slot = expected_slots.pop_back();
                slot.last_of_run = 1'b1;
                expected_slots.push_back(slot);
            end
        endfunction

        function void check_slot(input logic [DUTY_W-1:0] duty, input logic last_of_run);
            t_led_slot want;
            if (expected_slots.size() == 0) begin
                errors++;
                $display("%0t: unexpected output beat, expected none, actual duty %0d last %0b",
                         $time, duty, last_of_run);
                return;
            end
            want = expected_slots.pop_front();
            if (duty !== want.duty) begin
                errors++;
                $display("%0t: duty mismatch, expected %0d, actual %0d",
                         $time, want.duty, duty);
            end
            if (last_of_run !== want.last_of_run) begin
                errors++;
                $display("%0t: last_of_run mismatch, expected %0b, actual %0b",
                         $time, want.last_of_run, last_of_run);
            end
        endfunction

        function int pending();
            return expected_slots.size();
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DUTY_W-1:0]    i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic                 i_in_op     = OP_PIXEL;
    logic [CHAN_W-1:0]    i_in_red    = '0;
    logic [CHAN_W-1:0]    i_in_green  = '0;
    logic [CHAN_W-1:0]    i_in_blue   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [DUTY_W-1:0]    o_out_duty;
    logic                 o_out_last_of_run;

    duty_slot_predictor duty_pred;

    // Pacing modes: 0 runs flat out, 1 waits up to STALL_MAX on every beat,
    // 2 waits only now and then. Each side picks a new mode every 40 beats, so that
    // stretches without any idling alternate with heavy idling.
    int  tx_mode     = 1;
    int  rx_mode     = 1;
    int  tx_beats    = 0;
    int  rx_beats    = 0;
    int  idle_cycles = 0;
    // Set by the sender to ask the receiver for its one long hold-off.
    logic hold_req   = 1'b0;

    rgb_led_pulse_encoder dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_in_op           (i_in_op),
        .i_in_red          (i_in_red),
        .i_in_green        (i_in_green),
        .i_in_blue         (i_in_blue),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_duty        (o_out_duty),
        .o_out_last_of_run (o_out_last_of_run)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int draw_wait(input int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, STALL_MAX);
            default: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, STALL_MAX) : 0;
        endcase
    endfunction

    // Pad counts stay small most of the time to keep runs short, but the limit
    // and values above it (which saturate), and junk in the upper data bits, show up too.
    function automatic logic [DUTY_W-1:0] draw_pad();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return DUTY_W'($urandom_range(0, 4));
        else if (pick == 6)
            return DUTY_W'(MAX_PAD_SLOTS);
        else if (pick == 7)
            return DUTY_W'($urandom_range(MAX_PAD_SLOTS + 1, 63));
        else
            return DUTY_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [CHAN_W-1:0] draw_chan();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        else
            return CHAN_W'($urandom_range(0, 255));
    endfunction

    // Every handshake is observed here, at the rising edge. Inputs only change at the
    // falling edge and the encoder's outputs still hold their pre-edge values, so
    // nothing depends on the order of events within the step.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                duty_pred.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall)
                duty_pred.take_beat(i_in_op, i_in_red, i_in_green, i_in_blue);
            if (o_out_valid && !i_out_stall)
                duty_pred.check_slot(o_out_duty, o_out_last_of_run);
        end
    end

    // Watchdog: any beat on any channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_valid && o_cfg_ready) || (i_in_valid && !o_in_stall)
                || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Writes one register and waits for the encoder to take it.
    task automatic write_led_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUTY_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic program_regs(input logic [DUTY_W-1:0] one, input logic [DUTY_W-1:0] zero,
                                input logic [DUTY_W-1:0] gamma, input logic [DUTY_W-1:0] start,
                                input logic [DUTY_W-1:0] tail);
        write_led_reg(CFG_DUTY_ONE, one);
        write_led_reg(CFG_DUTY_ZERO, zero);
        write_led_reg(CFG_GAMMA_ON, gamma);
        write_led_reg(CFG_START_SLOTS, start);
        write_led_reg(CFG_TAIL_SLOTS, tail);
    endtask

    // Offers one input beat after a random gap and returns at the edge that takes it.
    // With a zero gap the valid stays high and only the payload moves on.
    task automatic send_led_beat(input logic op, input logic [CHAN_W-1:0] red,
                                 input logic [CHAN_W-1:0] green, input logic [CHAN_W-1:0] blue);
        int gap;
        gap = draw_wait(tx_mode);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_op    = op;
        i_in_red   = red;
        i_in_green = green;
        i_in_blue  = blue;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tx_beats++;
        if (tx_beats % 40 == 0)
            tx_mode = $urandom_range(0, 2);
    endtask

    // Stops offering beats and waits until every predicted slot has come out, then
    // lets the encoder settle. The first wait is a full edge so that the beat taken
    // just before has reached the predictor.
    task automatic drain_slots();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        do @(posedge i_clk); while (duty_pred.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Output side: one stall draw per beat, plus the single long hold-off on request.
    initial begin : slot_sink
        int n;
        wait (i_rst_n === 1'b1);
        forever begin
            n = draw_wait(rx_mode);
            if (hold_req) begin
                hold_req = 1'b0;
                n = HOLD_CYCLES;
            end
            @(negedge i_clk);
            i_out_stall = (n > 0);
            if (n > 0) begin
                repeat (n) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            rx_beats++;
            if (rx_beats % 40 == 0)
                rx_mode = $urandom_range(0, 2);
        end
    end

    initial begin : pixel_source
        int   ph;
        int   k;
        logic op;
        duty_pred = new();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Full-scale duty for ones, zero for zeros, no padding. Covers all-ones,
        // all-zeros and mixed pixels, and end-of-frame beats with a zero tail count
        // both inside and outside a frame (they emit nothing).
        program_regs(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_led_beat(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_led_beat(OP_PIXEL, 8'h00, 8'h00, 8'h00);
        send_led_beat(OP_PIXEL, 8'h80, 8'h01, 8'hA5);
        send_led_beat(OP_EOF, 8'hFF, 8'h00, 8'hFF);
        send_led_beat(OP_EOF, 8'h00, 8'hFF, 8'h00);
        send_led_beat(OP_PIXEL, 8'h55, 8'hAA, 8'h0F);
        drain_slots();

        // Inverted duties with gamma on. Both pad counts are above the limit and
        // must saturate. Writes to unused indexes must change nothing. The gamma
        // values sit at the points where the curve steps.
        program_regs(16'h0000, 16'hFFFF, 16'hFFFF, 16'h003F, 16'h0029);
        write_led_reg(CFG_IDX_W'(5), 16'hFFFF);
        write_led_reg(CFG_IDX_W'(6), 16'h1234);
        write_led_reg(CFG_IDX_W'(7), 16'h0001);
        send_led_beat(OP_PIXEL, 8'hFF, 8'h01, 8'h10);
        send_led_beat(OP_PIXEL, 8'h0F, 8'h80, 8'hF0);
        send_led_beat(OP_PIXEL, 8'h00, 8'hFF, 8'h02);
        send_led_beat(OP_EOF, 8'h12, 8'h34, 8'h56);
        send_led_beat(OP_EOF, 8'hFF, 8'hFF, 8'hFF);
        send_led_beat(OP_PIXEL, 8'h10, 8'h11, 8'hC8);
        drain_slots();

        // Start count exactly at the limit (junk in the upper data bits) and a
        // one-slot tail, first used on the frame still open from the previous group.
        program_regs(16'hA5A5, 16'h5A5A, 16'hFFFE, 16'hFF28, 16'h0001);
        send_led_beat(OP_EOF, 8'h00, 8'h00, 8'h00);
        send_led_beat(OP_PIXEL, 8'h01, 8'h02, 8'h03);
        send_led_beat(OP_PIXEL, 8'hFE, 8'h7F, 8'h80);
        send_led_beat(OP_EOF, 8'hAA, 8'h55, 8'hAA);
        drain_slots();

        // Random phases: mostly pixels in frames with random content, closed now and
        // then by an end of frame. Registers change only between phases.
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            program_regs(DUTY_W'($urandom_range(0, 65535)), DUTY_W'($urandom_range(0, 65535)),
                         DUTY_W'($urandom_range(0, 65535)), draw_pad(), draw_pad());
            // The receiver holds off for a long stretch while beats keep coming.
            if (ph == 0)
                hold_req = 1'b1;
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Once, the sender pauses until the encoder has fully drained.
                if (ph == 2 && k == ITEMS_PER_PHASE / 2)
                    drain_slots();
                op = ($urandom_range(0, 6) == 0) ? OP_EOF : OP_PIXEL;
                send_led_beat(op, draw_chan(), draw_chan(), draw_chan());
            end
            drain_slots();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (duty_pred.errors == 0 && duty_pred.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
design/rlpe_pkg.sv
design/rlpe_cell.sv
design/rlpe_shaper.sv
design/rgb_led_pulse_encoder.sv
bench/rgb_led_pulse_encoder_tb.sv
